[rtl/packed_depth_row_unpacker_assert.svh]
// Assertion macros shared by the checker of the depth row unpacker.
`ifndef PACKED_DEPTH_ROW_UNPACKER_ASSERT_SVH
`define PACKED_DEPTH_ROW_UNPACKER_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define PDRU_ASSERT_NOW(label, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |-> (rhs)) \
		else $error("pdru assertion failed");

// Next-cycle implication, clocked on clk and disabled during reset.
`define PDRU_ASSERT_NEXT(label, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |=> (rhs)) \
		else $error("pdru assertion failed");

`endif

[rtl/pdru_pkg.sv]
// Package of the depth row unpacker: pixel types and band constants.
package pdru_pkg;

	localparam logic [7:0] SKIP_A      = 8'd73;
	localparam logic [7:0] SKIP_B      = 8'd146;
	localparam logic [7:0] LAST_PACKET = 8'd241;
	localparam logic [7:0] BAND1_FIRST = 8'd74;
	localparam logic [7:0] BAND2_FIRST = 8'd147;
	localparam logic [7:0] BAND3_FIRST = 8'd220;
	localparam logic [3:0] BAND1_ADD   = 4'd8;
	localparam logic [3:0] BAND2_ADD   = 4'd4;
	localparam logic [10:0] WINDOW_BYTES = 11'd880;
	localparam logic [4:0] GROUP_BYTES  = 5'd11;
	localparam logic [6:0] RECIP_11     = 7'd93;
	localparam int         RECIP_SHIFT  = 10;

	localparam logic [3:0] K_PIX0 = 4'd1;
	localparam logic [3:0] K_PIX2 = 4'd4;
	localparam logic [3:0] K_PIX4 = 4'd6;
	localparam logic [3:0] K_PIX6 = 4'd9;

	typedef struct packed {
		logic [10:0] depth;
		logic [8:0]  column;
		logic [7:0]  row;
	} pdru_pix_t;

	typedef struct packed {
		logic      valid;
		logic      inflight;
		pdru_pix_t pix;
	} pdru_push_t;

endpackage

[rtl/pdru_front.sv]
// Front end: accepts bytes, finds the band and window, unpacks the pixel.
module pdru_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [7:0]          pkt,
	input  logic [10:0]         pos,
	input  logic [7:0]          cur,
	output pdru_pkg::pdru_push_t push
);

	logic        accept;
	logic        drop;
	logic [7:0]  base8;
	logic [6:0]  base;
	logic [3:0]  add;
	logic [7:0]  row_in;
	logic [10:0] offset;
	logic [11:0] diff;
	logic        in_win;

	logic        v_s1;
	logic        win_s1;
	logic [7:0]  row_s1;
	logic [9:0]  rel_s1;
	logic [7:0]  cur_s1;
	logic [7:0]  prev_s1;
	logic [7:0]  prev2_s1;
	logic [7:0]  prev_q;
	logic [7:0]  prev2_q;

	logic [16:0] prod;
	logic [6:0]  q_est;
	logic [10:0] eleven_q;
	logic [10:0] rem;
	logic [6:0]  group;
	logic [3:0]  k;
	logic [1:0]  sub;
	logic [10:0] depth;
	logic        emit;

	assign accept = in_valid && in_ready;

	always_comb begin
		drop   = (pkt == pdru_pkg::SKIP_A) || (pkt == pdru_pkg::SKIP_B) ||
			(pkt > pdru_pkg::LAST_PACKET);
		if (pkt >= pdru_pkg::BAND3_FIRST) begin
			base8  = pkt - pdru_pkg::BAND3_FIRST;
			add    = 4'd0;
			row_in = pkt - 8'd2;
		end else if (pkt >= pdru_pkg::BAND2_FIRST) begin
			base8  = pkt - pdru_pkg::BAND2_FIRST;
			add    = pdru_pkg::BAND2_ADD;
			row_in = pkt - 8'd2;
		end else if (pkt >= pdru_pkg::BAND1_FIRST) begin
			base8  = pkt - pdru_pkg::BAND1_FIRST;
			add    = pdru_pkg::BAND1_ADD;
			row_in = pkt - 8'd1;
		end else begin
			base8  = pkt;
			add    = 4'd0;
			row_in = pkt;
		end
		base   = base8[6:0];
		offset = {1'b0, base, 3'b000} + {2'b00, base, 2'b00} + {7'd0, add};
		diff   = {1'b0, pos} - {1'b0, offset};
		in_win = !drop && !diff[11] && (diff[10:0] < pdru_pkg::WINDOW_BYTES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			prev_q  <= 8'd0;
			prev2_q <= 8'd0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				prev_q  <= cur;
				prev2_q <= prev_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_s1   <= in_win;
			row_s1   <= row_in;
			rel_s1   <= diff[9:0];
			cur_s1   <= cur;
			prev_s1  <= prev_q;
			prev2_s1 <= prev2_q;
		end
	end

	// The estimate of rel / 11 is low by at most one, so one correction step fixes it.
	always_comb begin
		prod     = {7'd0, rel_s1} * {10'd0, pdru_pkg::RECIP_11};
		q_est    = prod[16:pdru_pkg::RECIP_SHIFT];
		eleven_q = {1'b0, q_est, 3'b000} + {3'b000, q_est, 1'b0} + {4'd0, q_est};
		rem      = {1'b0, rel_s1} - eleven_q;
		if (rem[4:0] >= pdru_pkg::GROUP_BYTES) begin
			group = q_est + 7'd1;
			k     = 4'(rem[4:0] - pdru_pkg::GROUP_BYTES);
		end else begin
			group = q_est;
			k     = rem[3:0];
		end
		emit  = 1'b1;
		sub   = 2'd0;
		depth = '0;
		case (k)
			pdru_pkg::K_PIX0: begin
				sub   = 2'd0;
				depth = {prev_s1, cur_s1[7:5]};
			end
			pdru_pkg::K_PIX2: begin
				sub   = 2'd1;
				depth = {prev2_s1[1:0], prev_s1, cur_s1[7]};
			end
			pdru_pkg::K_PIX4: begin
				sub   = 2'd2;
				depth = {prev_s1[3:0], cur_s1[7:1]};
			end
			pdru_pkg::K_PIX6: begin
				sub   = 2'd3;
				depth = {prev_s1[5:0], cur_s1[7:3]};
			end
			default: emit = 1'b0;
		endcase
	end

	assign push.valid      = v_s1 && win_s1 && emit;
	assign push.inflight   = v_s1;
	assign push.pix.row    = row_s1;
	assign push.pix.column = {group, sub};
	assign push.pix.depth  = depth;

endmodule

[rtl/pdru_fifo.sv]
// Back end: short pixel queue that drives the output stream.
module pdru_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pdru_pkg::pdru_push_t push,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pdru_pkg::pdru_pix_t  out_pix
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pdru_pkg::pdru_pix_t mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic          pop;

	assign out_valid = (count_q != '0);
	assign out_pix   = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign room      = ({1'b0, count_q} + (CW + 1)'(push.inflight)) < (CW + 1)'(DEPTH);

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_q] <= push.pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			count_q <= count_q + CW'(push.valid) - CW'(pop);
		end
	end

endmodule

[rtl/packed_depth_row_unpacker.sv]
// Top level of the depth row unpacker: 11-bit pixel unpack with decimation by two.
// A pixel goes through the classify register, then the pixel queue, to m_tdata.
// Throughput: one byte per cycle, set by the single classify stage and queue credit.
// Input stalls only when the pixel queue plus the byte in flight fill FIFO_DEPTH.
// Reset clears the two-byte history, the stage valid and the queue pointers.
module packed_depth_row_unpacker #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: packet_number[7:0], byte_position[18:8], data_byte[26:19], zeros[31:27]
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: row[7:0], column[16:8], depth[27:17], zeros[31:28]
	output logic [31:0] m_tdata
);

	pdru_pkg::pdru_push_t push;
	pdru_pkg::pdru_pix_t  pix;

	pdru_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.pkt      (s_tdata[7:0]),
		.pos      (s_tdata[18:8]),
		.cur      (s_tdata[26:19]),
		.push     (push)
	);

	pdru_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pix   (pix)
	);

	assign m_tdata = {4'd0, pix};

endmodule

[rtl/pdru_checker.sv]
// Port-level checker of the depth row unpacker and its bind.
`include "packed_depth_row_unpacker_assert.svh"

module pdru_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	logic in_word;

	assign in_word = s_tvalid && s_tready;

	`PDRU_ASSERT_NEXT(out_valid_holds, m_tvalid && !m_tready, m_tvalid)
	`PDRU_ASSERT_NEXT(out_word_holds, m_tvalid && !m_tready, $stable(m_tdata))
	`PDRU_ASSERT_NOW(out_word_range, m_tvalid, (m_tdata[7:0] <= 8'd239) && (m_tdata[16:8] <= 9'd319) && (m_tdata[31:28] == 4'd0))
	`PDRU_ASSERT_NOW(out_follows_input, $rose(m_tvalid), $past(in_word, 2))

endmodule

bind packed_depth_row_unpacker pdru_checker u_pdru_checker (.*);
